// ===== rtl/core/x10s_pkg.sv =====
// package for the x10 power-line frame sender
// item types, state type, sequence constants and the sequence bit decode
// no dependencies
package x10s_pkg;

  localparam logic ACT_SEND = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam int unsigned FRAME_LEN = 22;
  localparam int unsigned CMD_START = 2 * FRAME_LEN + 6;
  localparam int unsigned CMD_END   = 4 * FRAME_LEN + 6;
  localparam int unsigned SEQ_LAST  = 100;

  localparam logic [6:0] POS_CMD_START = 7'(CMD_START);
  localparam logic [6:0] POS_CMD_END   = 7'(CMD_END);
  localparam logic [6:0] POS_UNIT_END  = 7'(2 * FRAME_LEN);
  localparam logic [6:0] POS_LEN       = 7'(FRAME_LEN);
  localparam logic [6:0] POS_LAST      = 7'(SEQ_LAST);

  localparam logic REG_HOUSE_CODE = 1'b0;

  typedef struct packed {
    logic       action;
    logic [3:0] unit_code;
    logic [3:0] command_code;
  } in_item_t;

  typedef struct packed {
    logic carrier_burst;
    logic busy_res;
    logic next_bit;
  } out_item_t;

  typedef struct packed {
    logic [3:0] unit_latch;
    logic [3:0] command_latch;
    logic [6:0] bit_position;
    logic       sending;
  } tx_state_t;

  // nibble bit sent as a complementary pair, msb first
  function automatic logic pair_bit(logic [3:0] nibble, logic [2:0] off);
    logic b;
    b = nibble[2'd3 - off[2:1]];
    return off[0] ? ~b : b;
  endfunction

  function automatic logic frame_bit(logic [4:0] f, logic [3:0] house,
                                     logic [3:0] payload, logic is_cmd);
    logic [4:0] off_h;
    logic [4:0] off_p;
    off_h = f - 5'd4;
    off_p = f - 5'd12;
    if (f < 5'd3) return 1'b1;
    if (f == 5'd3) return 1'b0;
    if (f < 5'd12) return pair_bit(house, off_h[2:0]);
    if (f < 5'd20) return pair_bit(payload, off_p[2:0]);
    if (f == 5'd20) return is_cmd;
    return ~is_cmd;
  endfunction

  function automatic logic seq_bit(logic [6:0] pos, logic [3:0] house,
                                   logic [3:0] unit_nib, logic [3:0] cmd_nib);
    logic [6:0] rel;
    logic [6:0] f;
    rel = pos - POS_CMD_START;
    if (pos >= POS_LAST) return 1'b0;
    if (pos < POS_UNIT_END) begin
      f = (pos < POS_LEN) ? pos : pos - POS_LEN;
      return frame_bit(f[4:0], house, unit_nib, 1'b0);
    end
    if (pos < POS_CMD_START) return 1'b0;
    if (pos < POS_CMD_END) begin
      f = (rel < POS_LEN) ? rel : rel - POS_LEN;
      return frame_bit(f[4:0], house, cmd_nib, 1'b1);
    end
    return 1'b0;
  endfunction

endpackage

// ===== rtl/core/x10s_engine.sv =====
// per-item step of the x10 frame sender: next state and result item
// depends on x10s_pkg
module x10s_engine (
  input  x10s_pkg::in_item_t  item,
  input  x10s_pkg::tx_state_t st,
  input  logic [3:0]          house_code,
  output x10s_pkg::tx_state_t st_next,
  output x10s_pkg::out_item_t res
);

  logic       burst;
  logic [6:0] pos_inc;

  assign pos_inc = st.bit_position + 7'd1;

  always_comb begin
    st_next = st;
    burst   = 1'b0;
    if (item.action == x10s_pkg::ACT_SEND) begin
      if (!st.sending) begin
        st_next.unit_latch    = item.unit_code;
        st_next.command_latch = item.command_code;
        st_next.bit_position  = 7'd0;
        st_next.sending       = 1'b1;
      end
    end else if (st.sending) begin
      burst = x10s_pkg::seq_bit(st.bit_position, house_code, st.unit_latch,
                                st.command_latch);
      st_next.bit_position = pos_inc;
      if (pos_inc > x10s_pkg::POS_LAST) begin
        st_next.sending = 1'b0;
      end
    end
  end

  always_comb begin
    res.carrier_burst = burst;
    res.busy_res      = st_next.sending;
    res.next_bit      = st_next.sending &
                        x10s_pkg::seq_bit(st_next.bit_position, house_code,
                                          st_next.unit_latch, st_next.command_latch);
  end

endmodule

// ===== rtl/core/x10_powerline_frame_sender_top.sv =====
// X10-style power-line frame sender. A send item (action 0) latches a unit and
// a command nibble and starts a 101-position transmission when idle; each tick
// item (action 1) advances one position and reports whether a carrier burst
// starts. Every item gives one result item, registered after its input item is
// accepted (input register, then result register); one item is taken every
// cycle unless the output stalls, the state update being a single position
// decode and increment. house_code is written over the APB port at address 0.
// depends on x10s_pkg and x10s_engine
module x10_powerline_frame_sender_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  x10s_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output x10s_pkg::out_item_t out_item,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic                in_q_valid;
  x10s_pkg::in_item_t  in_q;
  x10s_pkg::tx_state_t st;
  x10s_pkg::tx_state_t st_next;
  x10s_pkg::out_item_t res;
  logic [3:0]          house_code;
  logic                advance;
  logic                cfg_wr;

  assign pready   = 1'b1;
  assign advance  = in_q_valid & (~out_valid | ~out_stall);
  assign in_stall = in_q_valid & out_valid & out_stall;
  assign cfg_wr   = psel & penable & pwrite & pready;

  always_comb begin
    prdata = 32'd0;
    if (paddr[2] == x10s_pkg::REG_HOUSE_CODE) begin
      prdata = {28'd0, house_code};
    end
  end

  x10s_engine u_engine (
    .item       (in_q),
    .st         (st),
    .house_code (house_code),
    .st_next    (st_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      house_code <= 4'd0;
    end else if (cfg_wr && paddr[2] == x10s_pkg::REG_HOUSE_CODE) begin
      house_code <= pwdata[3:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= '0;
      out_valid <= 1'b0;
    end else if (advance) begin
      st        <= st_next;
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item <= res;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    st.bit_position <= x10s_pkg::POS_LAST + 7'd1)
    else $error("bit position beyond end of sequence");

  a_idle_bit: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.busy_res |-> !out_item.next_bit)
    else $error("next_bit set while idle");

  a_burst_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.carrier_burst |-> out_item.busy_res)
    else $error("carrier burst ended the transmission");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !in_q_valid |-> !in_stall)
    else $error("input stalled with empty input register");
`endif

endmodule
